[rtl/ps2_mouse_packet_cursor_unit_macros.svh]
// Assertion macros shared by the checker of the cursor unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PMPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define PMPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/pmpc_pkg.sv]
// Shared types, constants and helpers of the PS/2 mouse packet cursor unit.
// Depends on nothing; every module of the unit imports it.
package pmpc_pkg;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 12;
    // Wide enough for a coordinate moved by a nine-bit signed delta
    localparam int SUM_W   = COORD_W + 2;

    // Reset values of the limits and the cursor
    localparam logic [COORD_W-1:0] RESET_X_LIMIT = COORD_W'(800 - 16);
    localparam logic [COORD_W-1:0] RESET_Y_LIMIT = COORD_W'(600 - 24);
    localparam logic [COORD_W-1:0] RESET_POS_X   = COORD_W'(800 / 2);
    localparam logic [COORD_W-1:0] RESET_POS_Y   = COORD_W'(600 / 2);

    // Bit positions in the flags byte
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MIDDLE = 2;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;
    localparam int FLAG_XOVF   = 6;
    localparam int FLAG_YOVF   = 7;

    // Configuration register indexes
    localparam logic CFG_X_LIMIT = 1'b0;
    localparam logic CFG_Y_LIMIT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x_limit;
        logic [COORD_W-1:0] y_limit;
    } t_limits;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               left_button;
        logic               right_button;
        logic               middle_button;
    } t_result;

    // Movement of one axis: nine-bit signed delta, or half the signed byte
    // (rounded toward zero) when the overflow flag is set
    function automatic logic signed [8:0] axis_delta(
        input logic [BYTE_W-1:0] b,
        input logic              neg,
        input logic              ovf
    );
        logic signed [8:0] full;
        logic signed [8:0] sb;
        logic signed [8:0] half;
        full = $signed({neg, b});
        sb   = $signed({b[BYTE_W-1], b});
        half = (sb + $signed({8'd0, b[BYTE_W-1]})) >>> 1;
        return ovf ? half : full;
    endfunction

    // Clamp a signed sum to 0..limit
    function automatic logic [COORD_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [COORD_W-1:0]      limit
    );
        logic signed [SUM_W-1:0] lim_s;
        lim_s = $signed({2'b00, limit});
        if (v <= 0) begin
            return '0;
        end else if (v >= lim_s) begin
            return limit;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

[rtl/ps2_mouse_packet_cursor_unit.sv]
// Top level of the PS/2 mouse packet cursor unit.
// Depends on pmpc_pkg, pmpc_cfg_regs, pmpc_in_stage, pmpc_packet_core, pmpc_out_reg.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------------
//   in       | input     | i_in_valid / o_in_stall | i_rx_byte
//   out      | output    | o_out_valid/ i_out_stall| o_cursor_x, o_cursor_y, o_*_button
//   cfg      | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One byte is accepted per cycle while the input is not stalled. A byte waits in the
// input register; the third byte of a packet runs from there through the add and clamp
// into the result register, from which its result can be taken.
// Synchronous active-low reset sets the limits to 784/576 and the cursor to 400/300.
// An output stall holds the result and, once the input register carries a third
// byte behind it, stalls the input.
module ps2_mouse_packet_cursor_unit
    import pmpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COORD_W-1:0] o_cursor_x,
    output logic [COORD_W-1:0] o_cursor_y,
    output logic               o_left_button,
    output logic               o_right_button,
    output logic               o_middle_button
);

    t_limits           limits;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              take;
    logic              out_free;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    pmpc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limits   (limits)
    );

    pmpc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    pmpc_packet_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_limits    (limits),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pmpc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_cursor_x      = out_res.cursor_x;
    assign o_cursor_y      = out_res.cursor_y;
    assign o_left_button   = out_res.left_button;
    assign o_right_button  = out_res.right_button;
    assign o_middle_button = out_res.middle_button;

endmodule

[rtl/pmpc_cfg_regs.sv]
// Limit registers of the cursor unit, written through a plain write port.
// Depends on pmpc_pkg.
module pmpc_cfg_regs
    import pmpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    output t_limits            o_limits
);

    t_limits r_limits;
    t_limits n_limits;

    // Pick the register addressed by the write
    always_comb begin
        n_limits = r_limits;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_LIMIT: n_limits.x_limit = i_cfg_data;
                CFG_Y_LIMIT: n_limits.y_limit = i_cfg_data;
                default:     n_limits = r_limits;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.x_limit <= RESET_X_LIMIT;
            r_limits.y_limit <= RESET_Y_LIMIT;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

[rtl/pmpc_in_stage.sv]
// Input register of the cursor unit: holds one received byte until the
// packet logic takes it. Depends on pmpc_pkg.
module pmpc_in_stage
    import pmpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    // Stall only while a held byte cannot move on
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[rtl/pmpc_packet_core.sv]
// Packet assembly and cursor update: groups bytes in threes and moves the
// clamped cursor on the third. Depends on pmpc_pkg.
module pmpc_packet_core
    import pmpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_limits           i_limits,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_DX    = 2'd1,
        POS_DY    = 2'd2
    } t_byte_pos;

    t_byte_pos           r_pos;
    t_byte_pos           n_pos;
    logic [BYTE_W-1:0]   r_flags;
    logic [BYTE_W-1:0]   r_dx;
    logic [COORD_W-1:0]  r_pos_x;
    logic [COORD_W-1:0]  r_pos_y;
    logic [COORD_W-1:0]  n_pos_x;
    logic [COORD_W-1:0]  n_pos_y;
    logic signed [8:0]   delta_x;
    logic signed [8:0]   delta_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic                last_byte;

    // The third byte needs room in the result register
    assign last_byte   = (r_pos == POS_DY);
    assign o_take      = i_valid && (!last_byte || i_out_free);
    assign o_res_valid = o_take && last_byte;

    // Move both axes: X adds its delta, Y subtracts it
    assign delta_x = axis_delta(r_dx, r_flags[FLAG_XSIGN], r_flags[FLAG_XOVF]);
    assign delta_y = axis_delta(i_byte, r_flags[FLAG_YSIGN], r_flags[FLAG_YOVF]);
    assign sum_x   = $signed({2'b00, r_pos_x}) + SUM_W'(delta_x);
    assign sum_y   = $signed({2'b00, r_pos_y}) - SUM_W'(delta_y);
    assign n_pos_x = clamp_axis(sum_x, i_limits.x_limit);
    assign n_pos_y = clamp_axis(sum_y, i_limits.y_limit);

    // Advance the byte position
    always_comb begin
        case (r_pos)
            POS_FLAGS: n_pos = POS_DX;
            POS_DX:    n_pos = POS_DY;
            POS_DY:    n_pos = POS_FLAGS;
            default:   n_pos = POS_FLAGS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FLAGS;
            r_flags <= '0;
            r_dx    <= '0;
            r_pos_x <= RESET_POS_X;
            r_pos_y <= RESET_POS_Y;
        end else if (o_take) begin
            r_pos <= n_pos;
            case (r_pos)
                POS_FLAGS: r_flags <= i_byte;
                POS_DX:    r_dx    <= i_byte;
                POS_DY: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                end
                default: r_flags <= r_flags;
            endcase
        end
    end

    always_comb begin
        o_res.cursor_x      = n_pos_x;
        o_res.cursor_y      = n_pos_y;
        o_res.left_button   = r_flags[FLAG_LEFT];
        o_res.right_button  = r_flags[FLAG_RIGHT];
        o_res.middle_button = r_flags[FLAG_MIDDLE];
    end

endmodule

[rtl/pmpc_out_reg.sv]
// Result register of the cursor unit: holds one result until the
// downstream side takes it. Depends on pmpc_pkg.
module pmpc_out_reg
    import pmpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or being emptied this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        if (i_res_valid) begin
            n_valid = 1'b1;
        end else if (i_out_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load a new result; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

[rtl/pmpc_checker.sv]
// Port-level checker of the cursor unit and its bind to the top level.
// Depends on pmpc_pkg and ps2_mouse_packet_cursor_unit_macros.svh.
`include "ps2_mouse_packet_cursor_unit_macros.svh"

module pmpc_checker
    import pmpc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [COORD_W-1:0] o_cursor_x,
    input logic [COORD_W-1:0] o_cursor_y
);

    logic [1:0] r_byte_cnt;
    logic [1:0] r_owed;
    logic [1:0] n_owed;
    logic       in_acc;
    logic       out_acc;
    logic       pkt_done;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = o_out_valid && !i_out_stall;
    assign pkt_done = in_acc && (r_byte_cnt == 2'd2);

    // Count completed packets not yet delivered
    always_comb begin
        n_owed = r_owed;
        if (pkt_done && !out_acc) begin
            n_owed = r_owed + 2'd1;
        end else if (!pkt_done && out_acc) begin
            n_owed = r_owed - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_owed     <= '0;
        end else begin
            r_owed <= n_owed;
            if (in_acc) begin
                r_byte_cnt <= (r_byte_cnt == 2'd2) ? 2'd0 : r_byte_cnt + 2'd1;
            end
        end
    end

    `PMPC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result shown right after reset")
    `PMPC_ASSERT(a_no_invented, o_out_valid |-> (r_owed != 2'd0), "result without a completed packet")
    `PMPC_ASSERT(a_stall_full, o_in_stall |-> (r_owed == 2'd2), "input stalled with room inside")
    `PMPC_ASSERT(a_hold_result, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_x) && $stable(o_cursor_y), "stalled result changed")

endmodule

bind ps2_mouse_packet_cursor_unit pmpc_checker u_pmpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_cursor_x  (o_cursor_x),
    .o_cursor_y  (o_cursor_y)
);
